### rtl/core/efas_pkg.sv
// Shared types, constants and codes of the earliest-finish accelerator selector.
package efas_pkg;

	// Field widths fixed by the request and result formats.
	localparam int REQ_W      = 2;
	localparam int TASK_W     = 4;
	localparam int TIME_W     = 40;
	localparam int PROF_W     = 32;
	localparam int FIN_W      = PROF_W + 1;
	localparam int TYPE_W     = 2;
	localparam int INST_W     = 2;
	localparam int STATUS_W   = 2;

	// Configuration register layout.
	localparam int REG_TYPES  = 4;
	localparam int COUNT_W    = 3;
	localparam int CAP_W      = 16;
	localparam int ACTIVE_W   = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Parameter defaults.
	localparam int NUM_TYPES_DEF      = 4;
	localparam int MAX_PER_TYPE_DEF   = 4;
	localparam int NUM_TASK_TYPES_DEF = 16;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TYPES = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INST_COUNTS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAP_TYPE0    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAP_TYPE1    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAP_TYPE2    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAP_TYPE3    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NO_TASK      = 3'd6;

	// Register reset values.
	localparam logic [ACTIVE_W-1:0]          ACTIVE_RST  = 3'd4;
	localparam logic [REG_TYPES*COUNT_W-1:0] COUNTS_RST  = 12'd2340;
	localparam logic [TASK_W-1:0]            NO_TASK_RST = 4'd15;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_SELECT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_BUSY   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FREE   = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOTASK = 2'd2;

	// Kind of result the controller asks the datapath to load.
	typedef logic [1:0] res_kind_t;
	localparam res_kind_t RES_ZERO   = 2'd0;
	localparam res_kind_t RES_NOTASK = 2'd1;
	localparam res_kind_t RES_SCAN   = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [TASK_W-1:0] task_class;
		logic [TIME_W-1:0] now_usec;
		logic [PROF_W-1:0] profile_type0;
		logic [PROF_W-1:0] profile_type1;
		logic [PROF_W-1:0] profile_type2;
		logic [PROF_W-1:0] profile_type3;
		logic [TYPE_W-1:0] slot_type;
		logic [INST_W-1:0] slot_instance;
		logic [PROF_W-1:0] running_profile;
	} in_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TYPE_W-1:0]   chosen_type;
		logic [INST_W-1:0]   chosen_instance;
		logic [FIN_W-1:0]    projected_finish;
	} out_t;

	typedef struct packed {
		logic [ACTIVE_W-1:0]                active_types;
		logic [REG_TYPES*COUNT_W-1:0]       instance_counts;
		logic [REG_TYPES-1:0][CAP_W-1:0]    cap_mask;
		logic [TASK_W-1:0]                  no_task_code;
	} cfg_t;

	// Controller to datapath.
	typedef struct packed {
		logic               start;
		logic               issue;
		logic [TYPE_W-1:0]  issue_type;
		logic [COUNT_W-1:0] issue_inst;
		logic               load_out;
		res_kind_t          res_kind;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} dp_status_t;

endpackage

### rtl/core/earliest_finish_accel_select.sv
// Top level of the earliest-finish accelerator selector.
// Usage: a request transfer on the input channel (in_valid high, in_stall low) carries
// one of three requests. A select asks for the accelerator slot with the earliest
// projected finish for a task; a busy mark records start time and run time for a
// slot; a free mark releases it. Every request gives exactly one result transfer on
// the output channel (out_valid high, out_stall low), in request order.
// Configuration is written through cfg_wr_en / cfg_index / cfg_wdata; the user must
// write it only while no request is in flight, as the block itself does not enforce
// this; a write to an index beyond the register list is dropped. Flow: the block
// handles one request at a time. Busy marks, free marks, rejected no-task selects and
// unknown requests go straight to the finish state, which loads the result once the
// output register is free; the block then returns to idle and can take the next
// request. A select walks the slots one per cycle through a three-stage finish-time
// pipeline, waits for the pipeline to drain and then loads the result in the same
// way once the output register is free. The result sits in an output register, so a
// stalled receiver only holds that result; the next request is taken meanwhile and
// waits at its end until the register is free. Reset frees every slot and loads the
// register defaults.
module earliest_finish_accel_select import efas_pkg::*; #(
	parameter int NUM_TYPES      = NUM_TYPES_DEF,
	parameter int MAX_PER_TYPE   = MAX_PER_TYPE_DEF,
	parameter int NUM_TASK_TYPES = NUM_TASK_TYPES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// Configuration registers.
	cfg_t cfg_q;

	logic       in_accept;
	cmd_t       cmd;
	dp_status_t sts;

	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_types <= ACTIVE_RST;
			cfg_q.instance_counts <= COUNTS_RST;
			cfg_q.cap_mask <= '0;
			cfg_q.no_task_code <= NO_TASK_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ACTIVE_TYPES: cfg_q.active_types <= cfg_wdata[ACTIVE_W-1:0];
				REG_INST_COUNTS:  cfg_q.instance_counts <= cfg_wdata[REG_TYPES*COUNT_W-1:0];
				REG_CAP_TYPE0:    cfg_q.cap_mask[0] <= cfg_wdata[CAP_W-1:0];
				REG_CAP_TYPE1:    cfg_q.cap_mask[1] <= cfg_wdata[CAP_W-1:0];
				REG_CAP_TYPE2:    cfg_q.cap_mask[2] <= cfg_wdata[CAP_W-1:0];
				REG_CAP_TYPE3:    cfg_q.cap_mask[3] <= cfg_wdata[CAP_W-1:0];
				REG_NO_TASK:      cfg_q.no_task_code <= cfg_wdata[TASK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The controller owns the request handshake and the scan order; the
	// datapath owns the slot table, the arithmetic and the result register.
	efas_ctrl #(
		.NUM_TYPES      (NUM_TYPES),
		.MAX_PER_TYPE   (MAX_PER_TYPE),
		.NUM_TASK_TYPES (NUM_TASK_TYPES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.sts       (sts),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	efas_dp #(
		.NUM_TYPES    (NUM_TYPES),
		.MAX_PER_TYPE (MAX_PER_TYPE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_stall (out_stall),
		.sts       (sts),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// A slot lookup is only issued while new requests are held off.
	a_issue_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> in_stall)
		else $error("slot lookup issued while input could transfer");

	// A result is never loaded over one that the receiver has not yet taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid && out_stall))
		else $error("result register overwritten while stalled");

	// Each accepted request keeps the input closed for at least the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> in_stall)
		else $error("second request taken right after a transfer");

endmodule

### rtl/core/efas_ctrl.sv
// Controller of the selector: accepts requests and walks the slot scan.
module efas_ctrl import efas_pkg::*; #(
	parameter int NUM_TYPES      = NUM_TYPES_DEF,
	parameter int MAX_PER_TYPE   = MAX_PER_TYPE_DEF,
	parameter int NUM_TASK_TYPES = NUM_TASK_TYPES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_accept,
	input  in_t        in_data,
	input  cfg_t       cfg,
	input  dp_status_t sts,
	output logic       in_stall,
	output cmd_t       cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	localparam int TYPE_LIM = (NUM_TYPES < REG_TYPES) ? NUM_TYPES : REG_TYPES;

	logic [1:0]         state_q, state_d;
	logic [TYPE_W-1:0]  type_q, type_d;
	logic [COUNT_W-1:0] inst_q, inst_d;
	res_kind_t          kind_q, kind_d;
	logic [TASK_W-1:0]  task_q;

	logic [ACTIVE_W-1:0] ntypes;
	logic [COUNT_W-1:0]  cnt_raw;
	logic [COUNT_W-1:0]  inst_lim;
	logic                capable;

	always_comb begin
		ntypes = (32'(cfg.active_types) > TYPE_LIM) ? ACTIVE_W'(TYPE_LIM) : cfg.active_types;
		cnt_raw = COUNT_W'(cfg.instance_counts >> (COUNT_W * type_q));
		inst_lim = (32'(cnt_raw) > MAX_PER_TYPE) ? COUNT_W'(MAX_PER_TYPE) : cnt_raw;
		capable = (32'(task_q) < NUM_TASK_TYPES) && cfg.cap_mask[type_q][task_q];
	end

	always_comb begin
		state_d = state_q;
		type_d = type_q;
		inst_d = inst_q;
		kind_d = kind_q;
		cmd = '0;
		cmd.issue_type = type_q;
		cmd.issue_inst = inst_q;
		cmd.res_kind = kind_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					if (in_data.req_type == REQ_SELECT) begin
						if (in_data.task_class == cfg.no_task_code) begin
							kind_d = RES_NOTASK;
							state_d = S_FINISH;
						end else begin
							cmd.start = 1'b1;
							kind_d = RES_SCAN;
							type_d = TYPE_W'(ntypes - 3'd1);
							inst_d = '0;
							state_d = (ntypes == '0) ? S_DRAIN : S_SCAN;
						end
					end else begin
						kind_d = RES_ZERO;
						state_d = S_FINISH;
					end
				end
			end
			S_SCAN: begin
				if (capable && (inst_q < inst_lim)) begin
					cmd.issue = 1'b1;
					inst_d = inst_q + 1'b1;
				end else if (type_q == '0) begin
					state_d = S_DRAIN;
				end else begin
					type_d = type_q - 1'b1;
					inst_d = '0;
				end
			end
			S_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			type_q <= '0;
			inst_q <= '0;
			kind_q <= RES_ZERO;
		end else begin
			state_q <= state_d;
			type_q <= type_d;
			inst_q <= inst_d;
			kind_q <= kind_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			task_q <= in_data.task_class;
		end
	end

endmodule

### rtl/core/efas_dp.sv
// Datapath of the selector: slot table, finish-time pipeline, best tracker, result register.
module efas_dp import efas_pkg::*; #(
	parameter int NUM_TYPES    = NUM_TYPES_DEF,
	parameter int MAX_PER_TYPE = MAX_PER_TYPE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_accept,
	input  in_t        in_data,
	input  cmd_t       cmd,
	input  logic       out_stall,
	output dp_status_t sts,
	output logic       out_valid,
	output out_t       out_data
);

	localparam int NUM_SLOTS = NUM_TYPES * MAX_PER_TYPE;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// Slot table.
	logic [NUM_SLOTS-1:0] busy_q;
	logic [TIME_W-1:0]    start_mem [NUM_SLOTS];
	logic [PROF_W-1:0]    run_mem   [NUM_SLOTS];

	// Request payload held for the scan.
	logic [TIME_W-1:0] now_q;
	logic [PROF_W-1:0] prof_q [REG_TYPES];

	logic              mark_ok;
	logic [SLOT_W-1:0] mark_addr;
	logic [SLOT_W-1:0] rd_addr;

	// Pipeline.
	logic               v_s1, v_s2, v_s3;
	logic               busy_s1, busy_s2;
	logic [TIME_W-1:0]  start_s1;
	logic [PROF_W-1:0]  run_s1, run_s2;
	logic [PROF_W-1:0]  prof_s1, prof_s2, prof_s3;
	logic [TYPE_W-1:0]  type_s1, type_s2, type_s3;
	logic [COUNT_W-1:0] inst_s1, inst_s2, inst_s3;
	logic [TIME_W-1:0]  elapsed_s2;
	logic [PROF_W-1:0]  rem_s3;

	logic [TIME_W:0]    elapsed_diff;
	logic [FIN_W-1:0]   finish_sum;
	logic               take_new;

	// Best candidate.
	logic               found_q;
	logic [FIN_W-1:0]   best_q;
	logic [TYPE_W-1:0]  best_type_q;
	logic [COUNT_W-1:0] best_inst_q;

	logic out_valid_q;
	out_t out_q;
	out_t res_d;

	always_comb begin
		mark_ok = in_accept
			&& ((in_data.req_type == REQ_BUSY) || (in_data.req_type == REQ_FREE))
			&& (32'(in_data.slot_type) < NUM_TYPES)
			&& (32'(in_data.slot_instance) < MAX_PER_TYPE);
		mark_addr = SLOT_W'(32'(in_data.slot_type) * MAX_PER_TYPE + 32'(in_data.slot_instance));
		rd_addr = SLOT_W'(32'(cmd.issue_type) * MAX_PER_TYPE + 32'(cmd.issue_inst));
		elapsed_diff = {1'b0, now_q} - {1'b0, start_s1};
		finish_sum = {1'b0, prof_s3} + {1'b0, rem_s3};
		take_new = v_s3 && (!found_q || (finish_sum < best_q));
	end

	always_ff @(posedge clk) begin
		if (mark_ok && (in_data.req_type == REQ_BUSY)) begin
			start_mem[mark_addr] <= in_data.now_usec;
			run_mem[mark_addr] <= in_data.running_profile;
		end
		if (cmd.issue) begin
			start_s1 <= start_mem[rd_addr];
			run_s1 <= run_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			now_q <= in_data.now_usec;
			prof_q[0] <= in_data.profile_type0;
			prof_q[1] <= in_data.profile_type1;
			prof_q[2] <= in_data.profile_type2;
			prof_q[3] <= in_data.profile_type3;
		end
		busy_s1 <= busy_q[rd_addr];
		prof_s1 <= prof_q[cmd.issue_type];
		type_s1 <= cmd.issue_type;
		inst_s1 <= cmd.issue_inst;

		// Elapsed time since the slot's start, zero if the start lies ahead.
		elapsed_s2 <= elapsed_diff[TIME_W] ? '0 : elapsed_diff[TIME_W-1:0];
		busy_s2 <= busy_s1;
		run_s2 <= run_s1;
		prof_s2 <= prof_s1;
		type_s2 <= type_s1;
		inst_s2 <= inst_s1;

		// Remaining run time, clamped at zero; a free slot has none.
		if (busy_s2 && (elapsed_s2 < {{(TIME_W-PROF_W){1'b0}}, run_s2})) begin
			rem_s3 <= run_s2 - elapsed_s2[PROF_W-1:0];
		end else begin
			rem_s3 <= '0;
		end
		prof_s3 <= prof_s2;
		type_s3 <= type_s2;
		inst_s3 <= inst_s2;

		if (take_new) begin
			best_q <= finish_sum;
			best_type_q <= type_s3;
			best_inst_q <= inst_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (mark_ok) begin
				busy_q[mark_addr] <= (in_data.req_type == REQ_BUSY);
			end
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.start) begin
				found_q <= 1'b0;
			end else if (take_new) begin
				found_q <= 1'b1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		res_d = '0;
		case (cmd.res_kind)
			RES_NOTASK: begin
				res_d.status = STATUS_NOTASK;
			end
			RES_SCAN: begin
				if (found_q) begin
					res_d.status = STATUS_OK;
					res_d.chosen_type = best_type_q;
					res_d.chosen_instance = best_inst_q[INST_W-1:0];
					res_d.projected_finish = best_q;
				end else begin
					res_d.status = STATUS_NONE;
				end
			end
			default: begin
				res_d.status = STATUS_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= res_d;
		end
	end

	assign sts.pipe_busy = v_s1 | v_s2 | v_s3;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

### test/tb_top.sv
// Self-checking testbench for the earliest-finish accelerator selector.
`timescale 1ns / 1ps

module tb_top;
	import efas_pkg::*;

	localparam int SLOTS           = NUM_TYPES_DEF * MAX_PER_TYPE_DEF;
	// The limit lies above the slowest correct run, even with every gap and
	// stall at full length, so it only trips on a hung block.
	localparam int CYCLE_LIMIT     = 400000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 40;
	localparam int MAX_PRINTED     = 40;
	localparam int RANDOM_PHASES   = 7;
	localparam int PHASE_ITEMS     = 70;

	// Codes that the package does not name: the unused request code and an
	// index past the end of the register list.
	localparam logic [REQ_W-1:0]     REQ_UNKNOWN = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_t                  out_data;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// Register copies kept by the testbench, updated as each write goes out.
	logic [ACTIVE_W-1:0]          cfg_active;
	logic [REG_TYPES*COUNT_W-1:0] cfg_counts;
	logic [CAP_W-1:0]             cfg_caps [REG_TYPES];
	logic [TASK_W-1:0]            cfg_no_task;

	// Slot table as the testbench sees it, indexed type * instances + instance.
	logic              occupied [SLOTS];
	logic [TIME_W-1:0] began_at [SLOTS];
	logic [PROF_W-1:0] runs_for [SLOTS];

	// Results owed by the block, oldest first.
	out_t outcomes_due [$];

	// Running notion of the current time, so that busy marks and selects in the
	// random part land close together and remaining run times matter.
	logic [TIME_W-1:0] sim_now;

	// When calm is set neither side idles at random, though a hold-off still applies.
	logic        calm;
	int unsigned hold_off_left = 0;
	int unsigned stall_left    = 0;
	int unsigned run_left      = 0;

	int unsigned cycle_n   = 0;
	int unsigned err_count = 0;
	int unsigned n_sent    = 0;
	int unsigned n_select  = 0;
	int unsigned n_results = 0;
	int unsigned n_writes  = 0;

	earliest_finish_accel_select dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Free-running cycle count; it also ends a run that hangs.
	always @(posedge clk) begin
		cycle_n++;
		if (cycle_n > CYCLE_LIMIT) begin
			$display("Run stopped at the cycle limit of %0d.", CYCLE_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	// Works out the result of one accepted request and applies any slot update.
	// A select scans capable types from the highest index down and instances from
	// the lowest up; only a strictly smaller projected finish replaces the best.
	function automatic out_t request_outcome(in_t r);
		out_t              res;
		logic [PROF_W-1:0] prof [REG_TYPES];
		logic [FIN_W-1:0]  best;
		logic [FIN_W-1:0]  fin;
		logic [TIME_W-1:0] elapsed;
		logic              found;
		int                ntypes;
		int                nslots;
		int                slot;
		res = '0;
		prof[0] = r.profile_type0;
		prof[1] = r.profile_type1;
		prof[2] = r.profile_type2;
		prof[3] = r.profile_type3;
		slot = int'(r.slot_type) * MAX_PER_TYPE_DEF + int'(r.slot_instance);
		case (r.req_type)
			REQ_BUSY: begin
				occupied[slot] = 1'b1;
				began_at[slot] = r.now_usec;
				runs_for[slot] = r.running_profile;
			end
			REQ_FREE: begin
				occupied[slot] = 1'b0;
			end
			REQ_SELECT: begin
				if (r.task_class == cfg_no_task) begin
					res.status = STATUS_NOTASK;
				end else begin
					// More active types than exist saturates.
					ntypes = (int'(cfg_active) > NUM_TYPES_DEF) ? NUM_TYPES_DEF : int'(cfg_active);
					found = 1'b0;
					best = '0;
					for (int t = ntypes - 1; t >= 0; t--) begin
						if (cfg_caps[t][r.task_class]) begin
							nslots = int'(cfg_counts[COUNT_W*t +: COUNT_W]);
							if (nslots > MAX_PER_TYPE_DEF)
								nslots = MAX_PER_TYPE_DEF;
							for (int i = 0; i < nslots; i++) begin
								slot = t * MAX_PER_TYPE_DEF + i;
								fin = FIN_W'(prof[t]);
								if (occupied[slot]) begin
									// A time before the start counts as no time elapsed.
									elapsed = (r.now_usec >= began_at[slot]) ?
										r.now_usec - began_at[slot] : '0;
									if (TIME_W'(runs_for[slot]) > elapsed)
										fin = fin + FIN_W'(TIME_W'(runs_for[slot]) - elapsed);
								end
								if (!found || fin < best) begin
									found = 1'b1;
									best = fin;
									res.chosen_type = TYPE_W'(t);
									res.chosen_instance = INST_W'(i);
								end
							end
						end
					end
					if (found)
						res.projected_finish = best;
					else
						res.status = STATUS_NONE;
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		if (err_count < MAX_PRINTED)
			$display("MISMATCH cycle %0d result %0d: %s", cycle_n, n_results, msg);
		err_count++;
	endtask

	task automatic check_field(string name, logic [FIN_W-1:0] got, logic [FIN_W-1:0] due);
		if (got !== due)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, due));
	endtask

	// Every result transfer is held against the oldest outstanding request.
	always @(posedge clk) begin : check_results
		out_t due;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (outcomes_due.size() == 0) begin
				report_mismatch("result transfer with no request outstanding");
			end else begin
				due = outcomes_due.pop_front();
				check_field("status", FIN_W'(out_data.status), FIN_W'(due.status));
				check_field("chosen_type", FIN_W'(out_data.chosen_type),
					FIN_W'(due.chosen_type));
				check_field("chosen_instance", FIN_W'(out_data.chosen_instance),
					FIN_W'(due.chosen_instance));
				check_field("projected_finish", out_data.projected_finish, due.projected_finish);
			end
		end
	end

	// Output side. A requested hold-off wins over everything; otherwise the
	// receiver mixes random stall bursts with random stretches of ready
	// cycles, unless calm is set.
	always @(posedge clk) begin
		if (hold_off_left != 0) begin
			out_stall <= 1'b1;
			hold_off_left--;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (calm || run_left != 0) begin
			out_stall <= 1'b0;
			if (run_left != 0)
				run_left--;
		end else if ($urandom_range(0, 2) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 14);
		end else begin
			out_stall <= 1'b0;
			run_left = $urandom_range(0, 30);
		end
	end

	// Offers one request and returns at the edge where its transfer happens. The
	// valid stays high afterwards, so back-to-back calls keep a request offered
	// without a gap; an optional idle burst comes before the request is offered.
	task automatic send_request(in_t r);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		outcomes_due.push_back(request_outcome(r));
		n_sent++;
		if (r.req_type == REQ_SELECT)
			n_select++;
	endtask

	// Drops valid and waits until every owed result has been taken, so that
	// the block is idle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (outcomes_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register writes only go out with the block idle. The enable drops
	// between writes.
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		n_writes++;
		case (idx)
			REG_ACTIVE_TYPES: cfg_active = data[ACTIVE_W-1:0];
			REG_INST_COUNTS:  cfg_counts = data[REG_TYPES*COUNT_W-1:0];
			REG_CAP_TYPE0:    cfg_caps[0] = data;
			REG_CAP_TYPE1:    cfg_caps[1] = data;
			REG_CAP_TYPE2:    cfg_caps[2] = data;
			REG_CAP_TYPE3:    cfg_caps[3] = data;
			REG_NO_TASK:      cfg_no_task = data[TASK_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic send_mark(logic [REQ_W-1:0] kind, logic [TYPE_W-1:0] st,
			logic [INST_W-1:0] si, logic [TIME_W-1:0] at, logic [PROF_W-1:0] run);
		in_t r;
		r = '0;
		r.req_type = kind;
		r.slot_type = st;
		r.slot_instance = si;
		r.now_usec = at;
		r.running_profile = run;
		send_request(r);
	endtask

	task automatic send_select(logic [TASK_W-1:0] tt, logic [TIME_W-1:0] at,
			logic [PROF_W-1:0] p0, logic [PROF_W-1:0] p1, logic [PROF_W-1:0] p2,
			logic [PROF_W-1:0] p3);
		in_t r;
		r = '0;
		r.req_type = REQ_SELECT;
		r.task_class = tt;
		r.now_usec = at;
		r.profile_type0 = p0;
		r.profile_type1 = p1;
		r.profile_type2 = p2;
		r.profile_type3 = p3;
		send_request(r);
	endtask

	// Random request. Most are shaped: busy marks that start near the running
	// time, selects a little later (now and then a little earlier), frees, with
	// small profiles so that ties and partly elapsed run times show up. A few are
	// pure noise across every bit of every field.
	function automatic in_t gen_request();
		in_t                 r;
		logic [7*32-1:0]     bits;
		int unsigned         pick;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r = bits[$bits(in_t)-1:0];
		pick = $urandom_range(0, 99);
		sim_now = sim_now + TIME_W'($urandom_range(0, 400));
		if (pick < 5)
			return r;
		r.now_usec = sim_now;
		if ($urandom_range(0, 4) != 0) begin
			r.profile_type0 = $urandom_range(0, 1500);
			r.profile_type1 = $urandom_range(0, 1500);
			r.profile_type2 = $urandom_range(0, 1500);
			r.profile_type3 = $urandom_range(0, 1500);
		end
		if (pick < 45) begin
			r.req_type = REQ_SELECT;
			if ($urandom_range(0, 9) == 0)
				r.now_usec = sim_now - TIME_W'($urandom_range(0, 500));
		end else if (pick < 78) begin
			r.req_type = REQ_BUSY;
			if ($urandom_range(0, 7) != 0)
				r.running_profile = $urandom_range(0, 3000);
		end else if (pick < 95) begin
			r.req_type = REQ_FREE;
		end else begin
			r.req_type = REQ_UNKNOWN;
		end
		return r;
	endfunction

	task automatic probe_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data,
			int n);
		write_register(idx, data);
		repeat (n) send_request(gen_request());
	endtask

	// Out of reset no type can run anything, so selects report no candidate
	// except for the no-task code.
	task automatic test_reset_defaults();
		repeat (10) send_request(gen_request());
		send_select(NO_TASK_RST, sim_now, '1, '1, '1, '1);
	endtask

	// Hand-picked cases. Capability narrows with the type index: task 14 runs
	// only on type 3, task 12 on types 3 and 2, task 0 everywhere.
	task automatic test_directed_selection();
		in_t r;
		write_register(REG_CAP_TYPE0, 16'h03FF);
		write_register(REG_CAP_TYPE1, 16'h0FFF);
		write_register(REG_CAP_TYPE2, 16'h3FFF);
		write_register(REG_CAP_TYPE3, 16'hFFFF);
		// All slots free: with equal profiles the first slot scanned wins, else the smallest profile.
		send_select(4'd0, '0, '0, '0, '0, '0);
		send_select(4'd0, '1, '1, '1, '1, '1);
		send_select(4'd0, 40'd100, 32'd5, 32'd6, 32'd7, 32'd8);
		// Two busy slots on type 0, one of them already past its run time.
		send_mark(REQ_BUSY, 2'd0, 2'd0, 40'd1000, 32'd500);
		send_mark(REQ_BUSY, 2'd0, 2'd1, 40'd1000, 32'd100);
		send_select(4'd0, 40'd1200, 32'd10, 32'd1000, 32'd1000, 32'd1000);
		// Current time before the start: the whole run time still remains.
		send_select(4'd0, 40'd900, 32'd10, 32'd1000, 32'd1000, 32'd1000);
		// Fill type 3 with the longest run time to reach the widest finish.
		for (int i = 0; i < MAX_PER_TYPE_DEF; i++)
			send_mark(REQ_BUSY, 2'd3, INST_W'(i), '0, '1);
		send_select(4'd14, '0, '0, '0, '0, '1);
		send_select(4'd14, '1, '1, '1, '1, '0);
		send_mark(REQ_FREE, 2'd3, 2'd0, '0, '0);
		send_select(4'd14, 40'd5, '0, '0, '0, 32'd3);
		// Equal finish on types 3 and 2: the higher type keeps it.
		send_select(4'd12, 40'd5, '0, '0, '1, '1);
		r = '1;
		r.req_type = REQ_UNKNOWN;
		send_request(r);
		send_select(NO_TASK_RST, 40'd5, '0, '0, '0, '0);
		send_mark(REQ_FREE, 2'd1, 2'd3, '1, '1);
	endtask

	// Each register at its extremes, including values that saturate and a write
	// past the end of the register list, which must change nothing.
	task automatic test_register_extremes();
		probe_setting(REG_ACTIVE_TYPES, 16'd0, 6);
		probe_setting(REG_ACTIVE_TYPES, 16'hFFFF, 8);
		probe_setting(REG_ACTIVE_TYPES, 16'd1, 6);
		probe_setting(REG_INST_COUNTS, 16'd0, 6);
		probe_setting(REG_INST_COUNTS, 16'hFFFF, 8);
		probe_setting(REG_INST_COUNTS, 16'o1052, 8);
		probe_setting(REG_NO_TASK, 16'd0, 8);
		probe_setting(REG_NO_TASK, 16'hFFF5, 8);
		probe_setting(REG_UNUSED, 16'hFFFF, 6);
		probe_setting(REG_CAP_TYPE2, 16'd0, 6);
		probe_setting(REG_CAP_TYPE0, 16'hFFFF, 6);
	endtask

	// Several random register settings, each followed by a batch of requests.
	// Write data is fully random so that unused upper bits are exercised too.
	task automatic test_random_settings();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_register(REG_ACTIVE_TYPES,
				($urandom_range(0, 3) == 0) ? CFG_DATA_W'(ACTIVE_RST) : CFG_DATA_W'($urandom));
			write_register(REG_INST_COUNTS,
				($urandom_range(0, 2) == 0) ? CFG_DATA_W'(COUNTS_RST) : CFG_DATA_W'($urandom));
			for (int k = 0; k < REG_TYPES; k++)
				write_register(CFG_IDX_W'(int'(REG_CAP_TYPE0) + k),
					($urandom_range(0, 3) == 0) ? 16'hFFFF : CFG_DATA_W'($urandom));
			write_register(REG_NO_TASK, CFG_DATA_W'($urandom));
			repeat (PHASE_ITEMS) send_request(gen_request());
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering
	// without gaps, so the block fills up and stalls its input.
	task automatic test_output_backpressure();
		wait_idle();
		calm = 1'b1;
		hold_off_left = HOLD_OFF_CYCLES;
		repeat (30) send_request(gen_request());
		calm = 1'b0;
	endtask

	// Closing stretch at full rate with no idling on either side.
	task automatic test_steady_stream();
		calm = 1'b1;
		wait_idle();
		while (stall_left != 0)
			@(posedge clk);
		repeat (40) send_request(gen_request());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		calm = 1'b0;
		cfg_active = ACTIVE_RST;
		cfg_counts = COUNTS_RST;
		cfg_no_task = NO_TASK_RST;
		for (int k = 0; k < REG_TYPES; k++)
			cfg_caps[k] = '0;
		for (int s = 0; s < SLOTS; s++) begin
			occupied[s] = 1'b0;
			began_at[s] = '0;
			runs_for[s] = '0;
		end
		sim_now = {8'($urandom), 32'($urandom)};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed_selection();
		test_register_extremes();
		test_random_settings();
		test_output_backpressure();
		test_steady_stream();

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d requests (%0d selects) under %0d register writes; %0d results checked.",
			n_sent, n_select, n_writes, n_results);
		$display("Run included a %0d-cycle output hold-off and a final stretch at full rate.",
			HOLD_OFF_CYCLES);
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
